/* hdl/bss_pkg.sv */
// Package for the bucket size statistics scan: beat types, configuration and register indexes.
`default_nettype none
package bss_pkg;

  localparam int FIELD_BITS     = 32;
  localparam int SYMBOL_BITS    = 8;
  localparam int CFG_INDEX_BITS = 2;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ALPHABET_SIZE = 2'd0,
    REG_TOTAL_WIDTH   = 2'd1,
    REG_START_PHASE   = 2'd2
  } cfg_reg_t;

  localparam logic [SYMBOL_BITS-1:0] ALPHABET_RESET = 8'd4;

  typedef struct packed {
    logic [SYMBOL_BITS-1:0] alphabet_size;
    logic [FIELD_BITS-1:0]  total_width;
    logic [SYMBOL_BITS-1:0] start_phase;
  } cfg_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] left_border;
    logic [FIELD_BITS-1:0] next_border;
    logic [FIELD_BITS-1:0] special_in;
    logic                  first_bucket;
    logic                  last_bucket;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] nonspecial_count;
    logic [FIELD_BITS-1:0] special_count;
    logic [FIELD_BITS-1:0] empty_count;
    logic [FIELD_BITS-1:0] max_nonspecial;
    logic [FIELD_BITS-1:0] max_special;
    logic [FIELD_BITS:0]   max_total;
    logic                  last_out;
  } out_item_t;

  // Beat between the border stage and the statistics stage
  typedef struct packed {
    logic [FIELD_BITS-1:0] border_count;
    logic [FIELD_BITS-1:0] special;
    logic                  first;
    logic                  last;
  } border_beat_t;

endpackage
`default_nettype wire

/* hdl/bss_border.sv */
// Input register stage: masks the counts and registers the saturated border difference.
`default_nettype none
module bss_border (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire bss_pkg::in_item_t                 in_data,
  input  wire bss_pkg::cfg_t                     cfg,
  input  wire logic [bss_pkg::FIELD_BITS-1:0]    count_mask,
  output logic                                   beat_valid,
  output bss_pkg::border_beat_t                  beat,
  input  wire logic                              beat_take
);

  logic [bss_pkg::FIELD_BITS-1:0] left;
  logic [bss_pkg::FIELD_BITS-1:0] right;
  logic                           no_right;
  bss_pkg::border_beat_t          beat_next;

  assign in_ready = !beat_valid || beat_take;

  // Pick the right border: total width for the last bucket, else the next border
  always_comb begin
    left     = in_data.left_border & count_mask;
    right    = in_data.last_bucket ? (cfg.total_width & count_mask)
                                   : (in_data.next_border & count_mask);
    no_right = !in_data.last_bucket && (right == '0);
    beat_next.border_count = (no_right || (right < left)) ? '0 : (right - left);
    beat_next.special      = in_data.special_in & count_mask;
    beat_next.first        = in_data.first_bucket;
    beat_next.last         = in_data.last_bucket;
  end

  // Hold the beat until the statistics stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (in_ready) begin
      beat_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat <= beat_next;
    end
  end

endmodule
`default_nettype wire

/* hdl/bss_stats.sv */
// Statistics stage: phase counter, special subtraction, running maxima and result register.
`default_nettype none
module bss_stats (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire bss_pkg::cfg_t          cfg,
  input  wire logic                   beat_valid,
  input  wire bss_pkg::border_beat_t  beat,
  output logic                        beat_take,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output bss_pkg::out_item_t          out_data
);

  localparam int FB = bss_pkg::FIELD_BITS;
  localparam int SB = bss_pkg::SYMBOL_BITS;

  logic [SB-1:0] phase, phase_next, phase_base, asz;
  logic [SB:0]   phase_inc;
  logic          wrap;
  logic [FB-1:0] empty_total, empty_next, empty_base;
  logic [FB-1:0] max_ns, max_ns_next, max_ns_base;
  logic [FB-1:0] max_sp, max_sp_next, max_sp_base;
  logic [FB:0]   max_tot, max_tot_next, max_tot_base;
  logic [FB-1:0] ns, sp;
  logic [FB:0]   tot;
  logic          fire;

  assign beat_take = !out_valid || out_ready;
  assign fire      = beat_valid && beat_take;

  // Work out the bucket counts and the updated statistics
  always_comb begin
    asz        = (cfg.alphabet_size == '0) ? {{(SB-1){1'b0}}, 1'b1} : cfg.alphabet_size;
    phase_base = beat.first ? cfg.start_phase : phase;
    phase_inc  = {1'b0, phase_base} + {{SB{1'b0}}, 1'b1};
    wrap       = phase_inc >= {1'b0, asz};
    phase_next = wrap ? '0 : phase_inc[SB-1:0];

    sp  = wrap ? beat.special : '0;
    ns  = (!wrap) ? beat.border_count
        : ((beat.border_count < beat.special) ? '0 : (beat.border_count - beat.special));
    tot = {1'b0, ns} + {1'b0, sp};

    empty_base   = beat.first ? '0 : empty_total;
    max_ns_base  = beat.first ? {{(FB-1){1'b0}}, 1'b1} : max_ns;
    max_sp_base  = beat.first ? {{(FB-1){1'b0}}, 1'b1} : max_sp;
    max_tot_base = beat.first ? {{FB{1'b0}}, 1'b1} : max_tot;

    empty_next   = (tot == '0) ? (empty_base + {{(FB-1){1'b0}}, 1'b1}) : empty_base;
    max_ns_next  = (ns > max_ns_base) ? ns : max_ns_base;
    max_sp_next  = (sp > max_sp_base) ? sp : max_sp_base;
    max_tot_next = (tot > max_tot_base) ? tot : max_tot_base;
  end

  // Advance the scan state on each beat taken
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= '0;
      empty_total <= '0;
      max_ns      <= {{(FB-1){1'b0}}, 1'b1};
      max_sp      <= {{(FB-1){1'b0}}, 1'b1};
      max_tot     <= {{FB{1'b0}}, 1'b1};
    end else if (fire) begin
      phase       <= phase_next;
      empty_total <= empty_next;
      max_ns      <= max_ns_next;
      max_sp      <= max_sp_next;
      max_tot     <= max_tot_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (beat_take) begin
      out_valid <= beat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.nonspecial_count <= ns;
      out_data.special_count    <= sp;
      out_data.empty_count      <= empty_next;
      out_data.max_nonspecial   <= max_ns_next;
      out_data.max_special      <= max_sp_next;
      out_data.max_total        <= max_tot_next;
      out_data.last_out         <= beat.last;
    end
  end

`ifndef SYNTHESIS
  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    (!beat_take) |=> ($stable(phase) && $stable(empty_total) && $stable(max_tot)))
    else $error("scan state moved while the result was stalled");

  a_phase_clears_on_wrap: assert property (@(posedge clk) disable iff (rst)
    (fire && wrap) |=> (phase == '0))
    else $error("phase not cleared after a wrap");

  a_first_restarts_empty: assert property (@(posedge clk) disable iff (rst)
    (fire && beat.first) |=> (empty_total <= {{(FB-1){1'b0}}, 1'b1}))
    else $error("empty count not restarted by a first bucket");

  a_total_bounds_parts: assert property (@(posedge clk) disable iff (rst)
    (max_tot >= {1'b0, max_ns}) && (max_tot >= {1'b0, max_sp}))
    else $error("maximum total below a partial maximum");
`endif

endmodule
`default_nettype wire

/* hdl/bucket_size_statistics_scan_core.sv */
// Top level of the bucket size statistics scan: configuration registers and the two stages.
`default_nettype none
// Takes one bucket beat per cycle unless stalled and returns one result beat per bucket.
// The border stage registers the saturated border difference; the statistics stage
// applies the phase counter, the special subtraction and the running maxima and holds
// the result register. Sustained rate is one bucket per cycle unless stalled, set by the
// single pass through the statistics stage. Configuration is written through
// cfg_we/cfg_index/cfg_data while the block is idle, a duty of the user that the block
// does not enforce; a first_bucket beat restarts the statistics and loads start_phase.
module bucket_size_statistics_scan_core #(
  parameter int COUNT_BITS = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [bss_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [bss_pkg::FIELD_BITS-1:0]        cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire bss_pkg::in_item_t                     in_data,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output bss_pkg::out_item_t                         out_data
);

  localparam int MaskBits = (COUNT_BITS < bss_pkg::FIELD_BITS) ? COUNT_BITS
                                                               : bss_pkg::FIELD_BITS;
  localparam logic [bss_pkg::FIELD_BITS:0] MaskWide =
    ({{bss_pkg::FIELD_BITS{1'b0}}, 1'b1} << MaskBits) - 1;
  localparam logic [bss_pkg::FIELD_BITS-1:0] CountMask = MaskWide[bss_pkg::FIELD_BITS-1:0];

  bss_pkg::cfg_t         cfg;
  bss_pkg::border_beat_t beat;
  logic                  beat_valid;
  logic                  beat_take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alphabet_size <= bss_pkg::ALPHABET_RESET;
      cfg.total_width   <= '0;
      cfg.start_phase   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bss_pkg::REG_ALPHABET_SIZE: cfg.alphabet_size <= cfg_data[bss_pkg::SYMBOL_BITS-1:0];
        bss_pkg::REG_TOTAL_WIDTH:   cfg.total_width   <= cfg_data;
        bss_pkg::REG_START_PHASE:   cfg.start_phase   <= cfg_data[bss_pkg::SYMBOL_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  bss_border u_border (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg        (cfg),
    .count_mask (CountMask),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take)
  );

  bss_stats u_stats (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire
